/* rtl/fat12te_pkg.sv */
// ============================================================================
// fat12te_pkg
// Shared types and codes of the FAT12 table engine: command and status
// codes, the chain-end marker and the memory control group.
// ============================================================================
package fat12te_pkg;

  localparam logic [2:0] CMD_RD_ENTRY = 3'd0;
  localparam logic [2:0] CMD_WR_ENTRY = 3'd1;
  localparam logic [2:0] CMD_COUNT    = 3'd2;
  localparam logic [2:0] CMD_FREE     = 3'd3;
  localparam logic [2:0] CMD_WR_BYTE  = 3'd4;
  localparam logic [2:0] CMD_RD_BYTE  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_LOOP  = 2'd2;

  // Links at or above this value end a chain.
  localparam logic [11:0] CHAIN_END = 12'hFF7;
  localparam logic [11:0] FIRST_DATA_CLUSTER = 12'd2;

  // Width of the walk limit and count; they must hold the entry count itself.
  localparam int LIMIT_W = 13;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

/* rtl/fat12te_if.sv */
// ============================================================================
// fat12te_if
// Valid/ready channels of the FAT12 table engine: command items, result
// items and the configuration write.
// ============================================================================
interface fat12te_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [10:0] cluster;
  logic [11:0] entry_value;
  logic [11:0] byte_addr;
  logic [7:0]  byte_in;

  modport source (output valid, cmd, cluster, entry_value, byte_addr, byte_in,
                  input ready);
  modport sink (input valid, cmd, cluster, entry_value, byte_addr, byte_in,
                output ready);
endinterface

interface fat12te_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] entry_out;
  logic [7:0]  byte_out;
  logic [11:0] chain_count;
  logic [1:0]  status;

  modport source (output valid, entry_out, byte_out, chain_count, status,
                  input ready);
  modport sink (input valid, entry_out, byte_out, chain_count, status,
                output ready);
endinterface

interface fat12te_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] clusters_in_use;

  modport source (output valid, clusters_in_use, input ready);
  modport sink (input valid, clusters_in_use, output ready);
endinterface

/* rtl/fat12_table_engine_core.sv */
// ============================================================================
// fat12_table_engine_core
// FAT12 table engine: packed 12-bit entries in a byte memory, with entry
// read/write, chain count, chain free and raw byte access.
// ============================================================================
// All access goes through the single-port byte memory: each entry takes two
// reads and, when modified, two writes. Items are handled one at a time; a new
// item is taken only after the last result has entered the result register.
// Reset (synchronous, active low) clears the sequencer and the result valid flag
// and sets clusters_in_use to 2048; the table is undefined until written.
module fat12_table_engine_core #(
  parameter int ENTRY_COUNT = 2048
) (
  input  logic           clk,
  input  logic           rst_n,
  fat12te_in_if.sink     in_if,
  fat12te_out_if.source  out_if,
  fat12te_cfg_if.sink    cfg_if
);

  localparam int TABLE_BYTES = (ENTRY_COUNT + 1) / 2 * 3;
  localparam int AW          = $clog2(TABLE_BYTES);
  localparam int LW          = fat12te_pkg::LIMIT_W;
  localparam logic [LW-1:0] ENTRY_LIM = LW'(ENTRY_COUNT);

  logic [11:0]            clusters_in_use_r;
  logic [LW-1:0]          limit;
  logic                   idle;
  fat12te_pkg::mem_ctl_t  mem_ctl;
  logic [AW-1:0]          mem_addr;
  logic [7:0]             mem_wdata;
  logic [7:0]             mem_rdata;

  assign cfg_if.ready = idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clusters_in_use_r <= 12'd2048;
    end else if (cfg_if.valid && cfg_if.ready) begin
      clusters_in_use_r <= cfg_if.clusters_in_use;
    end
  end

  // The walk is bounded by the smaller of the register and the entry count.
  assign limit = (LW'(clusters_in_use_r) < ENTRY_LIM) ? LW'(clusters_in_use_r) : ENTRY_LIM;

  fat12te_ctrl #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .TABLE_BYTES (TABLE_BYTES),
    .AW          (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .limit     (limit),
    .idle      (idle),
    .in_if     (in_if),
    .out_if    (out_if),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  fat12te_mem #(
    .DEPTH (TABLE_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

/* rtl/fat12te_mem.sv */
// ============================================================================
// fat12te_mem
// Single-port table byte memory: one read or write per cycle, registered
// read data.
// ============================================================================
module fat12te_mem #(
  parameter int DEPTH = 3072,
  parameter int AW    = 12
) (
  input  logic                clk,
  input  fat12te_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]       addr,
  input  logic [7:0]          wdata,
  output logic [7:0]          rdata
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/fat12te_ctrl.sv */
// ============================================================================
// fat12te_ctrl
// Command sequencer: entry reads and read-modify-writes over the packed
// byte memory, chain walks, raw byte access and the result register.
// ============================================================================
module fat12te_ctrl #(
  parameter int ENTRY_COUNT = 2048,
  parameter int TABLE_BYTES = 3072,
  parameter int AW          = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [fat12te_pkg::LIMIT_W-1:0]   limit,
  output logic                              idle,
  fat12te_in_if.sink                        in_if,
  fat12te_out_if.source                     out_if,
  output fat12te_pkg::mem_ctl_t             mem_ctl,
  output logic [AW-1:0]                     mem_addr,
  output logic [7:0]                        mem_wdata,
  input  logic [7:0]                        mem_rdata
);

  localparam int LW = fat12te_pkg::LIMIT_W;
  localparam logic [LW-1:0] ENTRY_LIM = LW'(ENTRY_COUNT);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ENT  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_RD1  = 4'd3;
  localparam logic [3:0] S_RD2  = 4'd4;
  localparam logic [3:0] S_WR0  = 4'd5;
  localparam logic [3:0] S_BWR  = 4'd6;
  localparam logic [3:0] S_BRD  = 4'd7;
  localparam logic [3:0] S_BRD2 = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [2:0]    cmd_r, cmd_nxt;
  logic [11:0]   cur_r, cur_nxt;
  logic [11:0]   val_r, val_nxt;
  logic [11:0]   addr_r, addr_nxt;
  logic [7:0]    bin_r, bin_nxt;
  logic [7:0]    b0_r, b0_nxt;
  logic [AW-1:0] a0_r, a0_nxt;
  logic [LW-1:0] count_r, count_nxt;
  logic [11:0]   eout_r, eout_nxt;
  logic [7:0]    bout_r, bout_nxt;
  logic [1:0]    status_r, status_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [11:0]   out_entry_r, out_entry_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic [11:0]   out_count_r, out_count_nxt;
  logic [1:0]    out_status_r, out_status_nxt;

  logic          in_acc;
  logic [AW-1:0] base;
  logic [AW-1:0] a0;
  logic          odd_r;
  logic [11:0]   entry;
  logic [11:0]   new_val;
  logic [7:0]    new_a0;
  logic [7:0]    new_a1;
  logic          addr_ok;

  assign idle        = (state_r == S_IDLE);
  assign in_if.ready = idle;
  assign in_acc      = in_if.valid && in_if.ready;

  // Entry pair k starts at byte 3k; an odd entry begins one byte further in.
  assign odd_r = cur_r[0];
  assign base  = AW'({cur_r[11:1], 1'b0}) + AW'(cur_r[11:1]);
  assign a0    = base + AW'(odd_r);

  // Byte at a0 is b0_r, byte at a0+1 arrives on the memory read data.
  assign entry   = odd_r ? {mem_rdata, b0_r[7:4]} : {mem_rdata[3:0], b0_r};
  assign new_val = (cmd_r == fat12te_pkg::CMD_WR_ENTRY) ? val_r : 12'd0;
  assign new_a1  = odd_r ? new_val[11:4] : {mem_rdata[7:4], new_val[11:8]};
  assign new_a0  = odd_r ? {new_val[3:0], b0_r[3:0]} : new_val[7:0];

  assign addr_ok = ({20'd0, addr_r} < 32'(TABLE_BYTES));

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    cur_nxt        = cur_r;
    val_nxt        = val_r;
    addr_nxt       = addr_r;
    bin_nxt        = bin_r;
    b0_nxt         = b0_r;
    a0_nxt         = a0_r;
    count_nxt      = count_r;
    eout_nxt       = eout_r;
    bout_nxt       = bout_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_entry_nxt  = out_entry_r;
    out_byte_nxt   = out_byte_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    mem_ctl        = '0;
    mem_addr       = a0_r;
    mem_wdata      = b0_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_if.cmd;
          cur_nxt    = {1'b0, in_if.cluster};
          val_nxt    = in_if.entry_value;
          addr_nxt   = in_if.byte_addr;
          bin_nxt    = in_if.byte_in;
          count_nxt  = '0;
          eout_nxt   = '0;
          bout_nxt   = '0;
          status_nxt = fat12te_pkg::ST_OK;
          case (in_if.cmd)
            fat12te_pkg::CMD_RD_ENTRY,
            fat12te_pkg::CMD_WR_ENTRY: state_nxt = S_ENT;
            fat12te_pkg::CMD_COUNT,
            fat12te_pkg::CMD_FREE:     state_nxt = S_CHK;
            fat12te_pkg::CMD_WR_BYTE:  state_nxt = S_BWR;
            fat12te_pkg::CMD_RD_BYTE:  state_nxt = S_BRD;
            default:                   state_nxt = S_FIN;
          endcase
        end
      end
      S_ENT: begin
        if (LW'(cur_r) >= ENTRY_LIM) begin
          status_nxt = fat12te_pkg::ST_RANGE;
          state_nxt  = S_FIN;
        end else begin
          mem_ctl.rd_en = 1'b1;
          mem_addr      = a0;
          a0_nxt        = a0;
          state_nxt     = S_RD1;
        end
      end
      S_CHK: begin
        if (cur_r >= fat12te_pkg::CHAIN_END) begin
          state_nxt = S_FIN;
        end else if (cur_r < fat12te_pkg::FIRST_DATA_CLUSTER || LW'(cur_r) >= limit) begin
          status_nxt = fat12te_pkg::ST_RANGE;
          state_nxt  = S_FIN;
        end else if (count_r >= limit) begin
          status_nxt = fat12te_pkg::ST_LOOP;
          state_nxt  = S_FIN;
        end else begin
          mem_ctl.rd_en = 1'b1;
          mem_addr      = a0;
          a0_nxt        = a0;
          state_nxt     = S_RD1;
        end
      end
      S_RD1: begin
        b0_nxt        = mem_rdata;
        mem_ctl.rd_en = 1'b1;
        mem_addr      = a0_r + AW'(1);
        state_nxt     = S_RD2;
      end
      S_RD2: begin
        // The second byte is written here, the first one in the next cycle.
        b0_nxt = new_a0;
        case (cmd_r)
          fat12te_pkg::CMD_RD_ENTRY: begin
            eout_nxt  = entry;
            state_nxt = S_FIN;
          end
          fat12te_pkg::CMD_WR_ENTRY: begin
            mem_ctl.wr_en = 1'b1;
            mem_addr      = a0_r + AW'(1);
            mem_wdata     = new_a1;
            state_nxt     = S_WR0;
          end
          fat12te_pkg::CMD_FREE: begin
            count_nxt     = count_r + LW'(1);
            eout_nxt      = entry;
            cur_nxt       = entry;
            mem_ctl.wr_en = 1'b1;
            mem_addr      = a0_r + AW'(1);
            mem_wdata     = new_a1;
            state_nxt     = S_WR0;
          end
          default: begin
            count_nxt = count_r + LW'(1);
            eout_nxt  = entry;
            cur_nxt   = entry;
            state_nxt = S_CHK;
          end
        endcase
      end
      S_WR0: begin
        mem_ctl.wr_en = 1'b1;
        mem_addr      = a0_r;
        mem_wdata     = b0_r;
        state_nxt     = (cmd_r == fat12te_pkg::CMD_WR_ENTRY) ? S_FIN : S_CHK;
      end
      S_BWR: begin
        if (addr_ok) begin
          mem_ctl.wr_en = 1'b1;
          mem_addr      = AW'(addr_r);
          mem_wdata     = bin_r;
        end else begin
          status_nxt = fat12te_pkg::ST_RANGE;
        end
        state_nxt = S_FIN;
      end
      S_BRD: begin
        if (addr_ok) begin
          mem_ctl.rd_en = 1'b1;
          mem_addr      = AW'(addr_r);
          state_nxt     = S_BRD2;
        end else begin
          status_nxt = fat12te_pkg::ST_RANGE;
          state_nxt  = S_FIN;
        end
      end
      S_BRD2: begin
        bout_nxt  = mem_rdata;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Wait for the result register to drain before handing over.
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_entry_nxt  = eout_r;
          out_byte_nxt   = bout_r;
          out_count_nxt  = count_r[11:0];
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    cur_r        <= cur_nxt;
    val_r        <= val_nxt;
    addr_r       <= addr_nxt;
    bin_r        <= bin_nxt;
    b0_r         <= b0_nxt;
    a0_r         <= a0_nxt;
    eout_r       <= eout_nxt;
    bout_r       <= bout_nxt;
    status_r     <= status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_byte_r   <= out_byte_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.entry_out   = out_entry_r;
  assign out_if.byte_out    = out_byte_r;
  assign out_if.chain_count = out_count_r;
  assign out_if.status      = out_status_r;

`ifndef SYNTHESIS
  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctl.rd_en && mem_ctl.wr_en))
    else $error("memory read and write issued in the same cycle");

  a_write_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.wr_en |-> (cmd_r == fat12te_pkg::CMD_WR_ENTRY ||
                       cmd_r == fat12te_pkg::CMD_FREE ||
                       cmd_r == fat12te_pkg::CMD_WR_BYTE))
    else $error("table write by a command that does not modify the table");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (count_r <= limit))
    else $error("chain count exceeds the walk limit");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_if.ready)
    else $error("a second item accepted before the first one finished");
`endif

endmodule

/* tb/tb_fat12_table_engine_core.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_fat12_table_engine_core
// Self-checking bench for the FAT12 table engine. A low region of the table
// is first loaded with links that stay inside that region or leave the valid
// range, and a high region with raw bytes. Directed items then cover byte and
// entry access, unused commands, the chain corner cases and a held-off receiver. After that,
// random phases at several cluster limits build linked chains and count or
// free them, mixed with raw traffic on the loaded regions. Every result is
// compared field by field with a local model of the packed table.
// ============================================================================
module tb_fat12_table_engine_core;

  localparam int ENTRY_COUNT    = 2048;
  localparam int TABLE_BYTES    = (ENTRY_COUNT + 1) / 2 * 3;
  localparam int CHAIN_ENTRIES  = 128;
  localparam int CHAIN_BYTES    = CHAIN_ENTRIES / 2 * 3;
  localparam int RAW_BYTES      = 192;
  localparam int RAW_BASE       = TABLE_BYTES - RAW_BYTES;
  localparam int RAW_ENTRY_BASE = RAW_BASE / 3 * 2;
  localparam int QUIET_LIMIT    = 30000;
  localparam int HOLD_CYCLES    = 400;
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  typedef struct packed {
    logic [11:0] entry_out;
    logic [7:0]  byte_out;
    logic [11:0] chain_count;
    logic [1:0]  status;
  } fat_result_t;

  bit clk = 1'b0;
  logic rst_n;

  fat12te_in_if  in_ch();
  fat12te_out_if out_ch();
  fat12te_cfg_if cfg_ch();

  fat12_table_engine_core #(.ENTRY_COUNT(ENTRY_COUNT)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #2 clk = ~clk;

  // Local copy of the packed table and of the cluster limit register.
  bit [7:0]    fat_bytes [TABLE_BYTES];
  bit [11:0]   clusters_cfg = 12'd2048;
  fat_result_t pending_results [$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  bit          gap_calm = 1'b0;
  bit          hold_toggle = 1'b0;

  function automatic bit [11:0] fat_entry(int idx);
    int base;
    base = (idx >> 1) * 3;
    if (idx % 2 == 1) begin
      return {fat_bytes[base + 2], fat_bytes[base + 1][7:4]};
    end
    return {fat_bytes[base + 1][3:0], fat_bytes[base]};
  endfunction

  function automatic void fat_store(int idx, bit [11:0] v);
    int base;
    base = (idx >> 1) * 3;
    if (idx % 2 == 1) begin
      fat_bytes[base + 2] = v[11:4];
      fat_bytes[base + 1][7:4] = v[3:0];
    end else begin
      fat_bytes[base + 1][3:0] = v[11:8];
      fat_bytes[base] = v[7:0];
    end
  endfunction

  // Applies one command to the local table and returns the result it gives.
  function automatic fat_result_t fat_command_result(logic [2:0] cmd, logic [10:0] cl,
                                                     logic [11:0] val, logic [11:0] addr,
                                                     logic [7:0] bin);
    fat_result_t r;
    int lim;
    int cur;
    int nxt;
    int visited;
    r = '0;
    visited = 0;
    lim = (clusters_cfg < ENTRY_COUNT) ? int'(clusters_cfg) : ENTRY_COUNT;
    case (cmd)
      fat12te_pkg::CMD_RD_ENTRY: begin
        if (cl < ENTRY_COUNT) r.entry_out = fat_entry(int'(cl));
        else r.status = fat12te_pkg::ST_RANGE;
      end
      fat12te_pkg::CMD_WR_ENTRY: begin
        if (cl < ENTRY_COUNT) fat_store(int'(cl), val);
        else r.status = fat12te_pkg::ST_RANGE;
      end
      fat12te_pkg::CMD_COUNT, fat12te_pkg::CMD_FREE: begin
        cur = int'(cl);
        while (cur < int'(fat12te_pkg::CHAIN_END)) begin
          if (cur < int'(fat12te_pkg::FIRST_DATA_CLUSTER) || cur >= lim) begin
            r.status = fat12te_pkg::ST_RANGE;
            break;
          end
          if (visited >= lim) begin
            r.status = fat12te_pkg::ST_LOOP;
            break;
          end
          nxt = int'(fat_entry(cur));
          if (cmd == fat12te_pkg::CMD_FREE) fat_store(cur, 12'd0);
          visited++;
          r.entry_out = nxt[11:0];
          cur = nxt;
        end
        r.chain_count = visited[11:0];
      end
      fat12te_pkg::CMD_WR_BYTE: begin
        if (addr < TABLE_BYTES) fat_bytes[addr] = bin;
        else r.status = fat12te_pkg::ST_RANGE;
      end
      fat12te_pkg::CMD_RD_BYTE: begin
        if (addr < TABLE_BYTES) r.byte_out = fat_bytes[addr];
        else r.status = fat12te_pkg::ST_RANGE;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (gap_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A link that either stays in the low region or is out of range for every
  // limit, so that walks never leave the loaded entries.
  function automatic bit [11:0] safe_link();
    if ($urandom_range(0, 3) == 0) return 12'($urandom_range(ENTRY_COUNT, 4095));
    return 12'($urandom_range(0, CHAIN_ENTRIES - 1));
  endfunction

  function automatic bit [11:0] bad_link(int lim);
    if ($urandom_range(0, 1)) return 12'($urandom_range(0, 1));
    if (lim < CHAIN_ENTRIES) return 12'($urandom_range(lim, CHAIN_ENTRIES - 1));
    return 12'($urandom_range(ENTRY_COUNT, 12'hFF6));
  endfunction

  function automatic int pick_loaded_byte();
    if ($urandom_range(0, 1)) return int'($urandom_range(0, CHAIN_BYTES - 1));
    return int'($urandom_range(RAW_BASE, TABLE_BYTES - 1));
  endfunction

  function automatic int pick_loaded_entry();
    if ($urandom_range(0, 1)) return int'($urandom_range(0, CHAIN_ENTRIES - 1));
    return int'($urandom_range(RAW_ENTRY_BASE, ENTRY_COUNT - 1));
  endfunction

  // Offers one item and returns at the edge where it is taken. Valid stays
  // high so that a following item can go out without a bubble.
  task automatic send_item(logic [2:0] cmd, logic [10:0] cl, logic [11:0] val,
                           logic [11:0] addr, logic [7:0] bin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.cmd         <= cmd;
    in_ch.cluster     <= cl;
    in_ch.entry_value <= val;
    in_ch.byte_addr   <= addr;
    in_ch.byte_in     <= bin;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(fat_command_result(cmd, cl, val, addr, bin));
    items_sent++;
  endtask

  task automatic write_entry(int cl, int v);
    send_item(fat12te_pkg::CMD_WR_ENTRY, 11'(cl), 12'(v), 12'($urandom), 8'($urandom));
  endtask

  task automatic read_entry(int cl);
    send_item(fat12te_pkg::CMD_RD_ENTRY, 11'(cl), 12'($urandom), 12'($urandom),
              8'($urandom));
  endtask

  task automatic walk_chain(logic [2:0] cmd, int cl);
    send_item(cmd, 11'(cl), 12'($urandom), 12'($urandom), 8'($urandom));
  endtask

  task automatic write_byte(int addr, int b);
    send_item(fat12te_pkg::CMD_WR_BYTE, 11'($urandom), 12'($urandom), 12'(addr), 8'(b));
  endtask

  task automatic read_byte(int addr);
    send_item(fat12te_pkg::CMD_RD_BYTE, 11'($urandom), 12'($urandom), 12'(addr),
              8'($urandom));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_cluster_limit(int v);
    drain_results();
    cfg_ch.clusters_in_use <= 12'(v);
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    clusters_cfg = 12'(v);
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic load_table();
    bit [11:0] e0;
    bit [11:0] e1;
    for (int k = 0; k < CHAIN_ENTRIES / 2; k++) begin
      gap_calm = (k % 32) < 16;
      e0 = safe_link();
      e1 = safe_link();
      write_byte(3 * k, int'(e0[7:0]));
      write_byte(3 * k + 1, int'({e1[3:0], e0[11:8]}));
      write_byte(3 * k + 2, int'(e1[11:4]));
    end
    for (int a = RAW_BASE; a < TABLE_BYTES; a++) begin
      gap_calm = (a % 64) < 32;
      write_byte(a, int'($urandom_range(0, 255)));
    end
    gap_calm = 1'b0;
  endtask

  task automatic test_byte_access();
    write_byte(0, 8'h00);
    write_byte(TABLE_BYTES - 1, 8'hFF);
    read_byte(0);
    read_byte(TABLE_BYTES - 1);
    write_byte(TABLE_BYTES, 8'hA5);
    read_byte(12'hFFF);
  endtask

  task automatic test_entry_access();
    write_entry(0, 12'hFFF);
    write_entry(ENTRY_COUNT - 1, 12'h000);
    read_entry(0);
    read_entry(ENTRY_COUNT - 1);
    // The shared middle byte shows both nibble halves of a packed pair.
    read_byte(1);
  endtask

  task automatic test_unused_commands();
    send_item(CMD_SPARE_A, 11'h7FF, 12'hFFF, 12'hFFF, 8'hFF);
    send_item(CMD_SPARE_B, 11'h000, 12'h000, 12'h000, 8'h00);
  endtask

  task automatic test_chain_cases();
    write_entry(2, 3);
    write_entry(3, fat12te_pkg::CHAIN_END);
    walk_chain(fat12te_pkg::CMD_COUNT, 2);
    walk_chain(fat12te_pkg::CMD_FREE, 2);
    read_entry(2);
    walk_chain(fat12te_pkg::CMD_COUNT, 0);
    walk_chain(fat12te_pkg::CMD_FREE, 1);
    // A link beyond the table stops the walk after the first cluster.
    write_entry(5, 12'h800);
    walk_chain(fat12te_pkg::CMD_COUNT, 5);
    write_entry(6, 12'hFF6);
    walk_chain(fat12te_pkg::CMD_COUNT, 6);
    // Two clusters pointing at each other run into the walk limit.
    write_entry(10, 11);
    write_entry(11, 10);
    walk_chain(fat12te_pkg::CMD_COUNT, 10);
    walk_chain(fat12te_pkg::CMD_FREE, 10);
  endtask

  // The receiver holds off while items keep coming, so the input stalls.
  task automatic test_input_backpressure();
    drain_results();
    hold_toggle = ~hold_toggle;
    gap_calm = 1'b1;
    for (int k = 0; k < 16; k++) read_byte(int'($urandom_range(0, CHAIN_BYTES - 1)));
    gap_calm = 1'b0;
    drain_results();
  endtask

  task automatic random_noise_item(int lim);
    int free_top;
    free_top = (lim + 1 < CHAIN_ENTRIES) ? lim + 1 : CHAIN_ENTRIES - 1;
    case ($urandom_range(0, 6))
      0: write_byte($urandom_range(0, 9) == 0 ? $urandom_range(TABLE_BYTES, 4095)
                                              : $urandom_range(RAW_BASE, TABLE_BYTES - 1),
                    $urandom_range(0, 255));
      1: read_byte($urandom_range(0, 9) == 0 ? int'($urandom_range(TABLE_BYTES, 4095))
                                             : pick_loaded_byte());
      2: read_entry(pick_loaded_entry());
      3: begin
        if ($urandom_range(0, 1)) begin
          write_entry($urandom_range(0, CHAIN_ENTRIES - 1), int'(safe_link()));
        end else begin
          write_entry($urandom_range(RAW_ENTRY_BASE, ENTRY_COUNT - 1),
                      $urandom_range(0, 4095));
        end
      end
      4: walk_chain(fat12te_pkg::CMD_COUNT, $urandom_range(0, CHAIN_ENTRIES - 1));
      5: walk_chain(fat12te_pkg::CMD_FREE, $urandom_range(0, free_top));
      default: send_item($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B,
                         11'($urandom), 12'($urandom), 12'($urandom), 8'($urandom));
    endcase
  endtask

  // Builds a chain over distinct clusters below the limit, sometimes broken by a
  // loop or a bad link, then counts and possibly frees it; with a limit under 3 it only counts.
  task automatic random_chain(int lim);
    int len;
    int c;
    int kind;
    int top;
    int nodes [$];
    bit taken [CHAIN_ENTRIES];
    bit [11:0] tail;
    if (lim < 3) begin
      walk_chain(fat12te_pkg::CMD_COUNT, $urandom_range(0, CHAIN_ENTRIES - 1));
      return;
    end
    top = (lim < CHAIN_ENTRIES) ? lim : CHAIN_ENTRIES;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
    if (len > top - 2) len = top - 2;
    for (int k = 0; k < len; k++) begin
      do c = $urandom_range(2, top - 1); while (taken[c]);
      taken[c] = 1'b1;
      nodes.push_back(c);
    end
    kind = $urandom_range(0, 19);
    if (kind < 3) tail = 12'(nodes[$urandom_range(0, len - 1)]);
    else if (kind < 5) tail = bad_link(lim);
    else tail = 12'($urandom_range(fat12te_pkg::CHAIN_END, 12'hFFF));
    for (int k = 0; k < len; k++) begin
      write_entry(nodes[k], (k == len - 1) ? int'(tail) : nodes[k + 1]);
    end
    walk_chain(fat12te_pkg::CMD_COUNT,
               nodes[$urandom_range(0, 3) == 0 ? $urandom_range(0, len - 1) : 0]);
    if ($urandom_range(0, 1)) read_entry(nodes[$urandom_range(0, len - 1)]);
    if ($urandom_range(0, 1)) begin
      walk_chain(fat12te_pkg::CMD_FREE, nodes[0]);
      walk_chain(fat12te_pkg::CMD_COUNT, nodes[0]);
    end
  endtask

  task automatic test_random_phase(int lim, int n_items);
    int stop_at;
    write_cluster_limit(lim);
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      gap_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 6) random_chain(lim);
      else random_noise_item(lim);
    end
    gap_calm = 1'b0;
    drain_results();
  endtask

  // ------------------------------------------------------- result sink

  int stall_left = 0;
  int hold_left = 0;
  int calm_left = 300;
  bit sink_calm = 1'b0;
  bit hold_seen = 1'b0;

  always @(posedge clk) begin
    fat_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result item arrived with nothing pending");
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.entry_out !== exp_r.entry_out) begin
          $error("entry_out: expected %0h, got %0h", exp_r.entry_out, out_ch.entry_out);
          mismatch_count++;
        end
        if (out_ch.byte_out !== exp_r.byte_out) begin
          $error("byte_out: expected %0h, got %0h", exp_r.byte_out, out_ch.byte_out);
          mismatch_count++;
        end
        if (out_ch.chain_count !== exp_r.chain_count) begin
          $error("chain_count: expected %0d, got %0d", exp_r.chain_count,
                 out_ch.chain_count);
          mismatch_count++;
        end
        if (out_ch.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_ch.status);
          mismatch_count++;
        end
      end
    end

    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!sink_calm && $urandom_range(0, 7) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                 : $urandom_range(1, 3);
      end
    end

    calm_left--;
    if (calm_left == 0) begin
      sink_calm = ($urandom_range(0, 2) == 0);
      calm_left = $urandom_range(100, 600);
    end
  end

  // ---------------------------------------------------------- watchdog

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------- main

  initial begin
    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.cmd              <= fat12te_pkg::CMD_RD_ENTRY;
    in_ch.cluster          <= '0;
    in_ch.entry_value      <= '0;
    in_ch.byte_addr        <= '0;
    in_ch.byte_in          <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.clusters_in_use <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_table();
    test_byte_access();
    test_entry_access();
    test_unused_commands();
    test_chain_cases();
    test_input_backpressure();
    test_random_phase(2, 190);
    test_random_phase(3, 190);
    test_random_phase(17, 190);
    test_random_phase(100, 190);
    test_random_phase(1000, 190);
    test_random_phase(2047, 190);
    test_random_phase(2048, 190);

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
